@@ rtl/bpa_pkg.sv @@
// Package for the bitmap page allocator: sizes, codes and transfer types.
package bpa_pkg;

  localparam int BITMAP_WORDS = 1024;
  localparam int PAGE_BYTES   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int WORD_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int PAGE_W       = WORD_W + BIT_W;
  localparam int CAPACITY     = BITMAP_WORDS * WORD_BITS;

  localparam int ADDR_W = 27;
  localparam int CNT_W  = 16;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int NW_W   = CNT_W + 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] RESET_LIMIT    = 16'd4096;
  localparam logic [CNT_W-1:0] RESET_RESERVED = 16'd256;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_REJECT = 2'd2;

  localparam logic REG_PAGE_LIMIT = 1'b0;
  localparam logic REG_RESERVED   = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] page_address;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  free_pages;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ALLOC = 4'b0010,
    S_FREE  = 4'b0100,
    S_CLEAR = 4'b1000
  } state_t;

endpackage

@@ rtl/bitmap_page_allocator_unit.sv @@
// Top level of the first-fit bitmap page allocator with its register port.
//
// Commands enter on start/in_data and are taken at an edge where start is
// high and busy is low. Each command gives exactly one result, shown on
// out_data for one cycle with out_valid high; the receiver cannot stall.
// The bitmap sits in a 1024 x 32 RAM with registered reads; allocate and
// free are read-modify-writes on it, one command at a time.
// Steps from the accepting edge to the result strobe:
//   allocate  : scans from word 0, one word a cycle, until a word holds a
//               free page or the last word below the limit has been read.
//   free      : reads the page's word and writes it back with the bit clear;
//               a rejected free or an unused code does not touch the RAM.
//   clear     : rewrites every RAM word, one word a cycle.
// busy drops in the cycle the result is shown, so the next command can be
// taken then. After reset the block runs the same clearing pass (reserving
// 256 pages) with busy high and no result; register writes over the APB
// port are taken at any time and should be made idle.
module bitmap_page_allocator_unit
  import bpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  state_t state_r, state_nxt;
  logic [WORD_W-1:0] cur_w_r, cur_w_nxt;
  logic [WORD_W-1:0] free_w_r, free_w_nxt;
  logic [BIT_W-1:0]  free_bit_r, free_bit_nxt;
  logic [CNT_W-1:0]  used_count_r, used_count_nxt;
  logic [CNT_W-1:0]  clr_n_r, clr_n_nxt;
  logic              clr_report_r, clr_report_nxt;
  logic [CNT_W-1:0]  limit_r, reserved_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic accept;
  logic cfg_write;
  logic [CNT_W-1:0] eff_limit, eff_reserved, limit_word, full_w;
  logic [NW_W-1:0]  num_words;

  logic [ADDR_W-PAGE_SHIFT-1:0] free_pg_full;
  logic [PAGE_W-1:0]            free_page;
  logic                         free_ok;

  logic [WORD_BITS-1:0] hi_mask, masked, clr_pattern;
  logic                 alloc_found, alloc_last;
  logic [BIT_W-1:0]     alloc_bit;

  logic [ST_W-1:0]   res_status;
  logic [PAGE_W-1:0] res_page;
  logic              res_has_page;
  logic [PAGE_W+PAGE_SHIFT-1:0] res_bytes;

  logic                 ram_we, ram_re;
  logic [WORD_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign eff_limit    = (32'(limit_r) < CAPACITY) ? limit_r : CNT_W'(CAPACITY);
  assign eff_reserved = (32'(reserved_r) < CAPACITY) ? reserved_r : CNT_W'(CAPACITY);
  assign limit_word   = eff_limit >> BIT_W;
  assign num_words    = (NW_W'(eff_limit) + NW_W'(WORD_BITS - 1)) >> BIT_W;
  assign full_w       = clr_n_r >> BIT_W;

  assign free_pg_full = in_data.address[ADDR_W-1:PAGE_SHIFT];
  assign free_page    = PAGE_W'(free_pg_full);
  assign free_ok      = (in_data.address[PAGE_SHIFT-1:0] == '0) &&
                        (32'(free_pg_full) < 32'(eff_limit));

  // Pages at or above the limit count as taken during the scan.
  always_comb begin
    if (32'(cur_w_r) < 32'(limit_word)) begin
      hi_mask = '0;
    end else if (32'(cur_w_r) == 32'(limit_word)) begin
      hi_mask = ~((WORD_BITS'(1) << eff_limit[BIT_W-1:0]) - WORD_BITS'(1));
    end else begin
      hi_mask = '1;
    end
  end

  assign masked      = ram_rdata | hi_mask;
  assign alloc_found = (masked != '1);
  assign alloc_last  = (32'(cur_w_r) + 32'd1 >= 32'(num_words));

  always_comb begin
    alloc_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!masked[b]) begin
        alloc_bit = BIT_W'(b);
      end
    end
  end

  always_comb begin
    if (32'(cur_w_r) < 32'(full_w)) begin
      clr_pattern = '1;
    end else if (32'(cur_w_r) == 32'(full_w)) begin
      clr_pattern = (WORD_BITS'(1) << clr_n_r[BIT_W-1:0]) - WORD_BITS'(1);
    end else begin
      clr_pattern = '0;
    end
  end

  // Bitmap RAM access.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cur_w_r + WORD_W'(1);
    ram_we    = 1'b0;
    ram_waddr = cur_w_r;
    ram_wdata = clr_pattern;
    case (state_r)
      S_IDLE: begin
        if (accept && in_data.operation == OP_ALLOC) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end else if (accept && in_data.operation == OP_FREE && free_ok) begin
          ram_re    = 1'b1;
          ram_raddr = free_page[PAGE_W-1:BIT_W];
        end
      end
      S_ALLOC: begin
        ram_re = !alloc_found && !alloc_last;
        if (alloc_found) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << alloc_bit);
        end
      end
      S_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = free_w_r;
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << free_bit_r);
      end
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cur_w_nxt      = cur_w_r;
    free_w_nxt     = free_w_r;
    free_bit_nxt   = free_bit_r;
    used_count_nxt = used_count_r;
    clr_n_nxt      = clr_n_r;
    clr_report_nxt = clr_report_r;
    out_valid_nxt  = 1'b0;
    res_status     = ST_DONE;
    res_page       = '0;
    res_has_page   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_ALLOC: begin
              state_nxt = S_ALLOC;
              cur_w_nxt = '0;
            end
            OP_FREE: begin
              if (free_ok) begin
                state_nxt    = S_FREE;
                free_w_nxt   = free_page[PAGE_W-1:BIT_W];
                free_bit_nxt = free_page[BIT_W-1:0];
              end else begin
                out_valid_nxt = 1'b1;
                res_status    = ST_REJECT;
              end
            end
            OP_CLEAR: begin
              state_nxt      = S_CLEAR;
              cur_w_nxt      = '0;
              clr_n_nxt      = eff_reserved;
              clr_report_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (alloc_found) begin
          if (used_count_r != '1) begin
            used_count_nxt = used_count_r + CNT_W'(1);
          end
          out_valid_nxt = 1'b1;
          res_page      = {cur_w_r, alloc_bit};
          res_has_page  = 1'b1;
          state_nxt     = S_IDLE;
        end else if (alloc_last) begin
          out_valid_nxt = 1'b1;
          res_status    = ST_NOFREE;
          state_nxt     = S_IDLE;
        end else begin
          cur_w_nxt = cur_w_r + WORD_W'(1);
        end
      end
      S_FREE: begin
        if (used_count_r != '0) begin
          used_count_nxt = used_count_r - CNT_W'(1);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CLEAR: begin
        if (cur_w_r == WORD_W'(BITMAP_WORDS - 1)) begin
          used_count_nxt = clr_n_r;
          out_valid_nxt  = clr_report_r;
          state_nxt      = S_IDLE;
          cur_w_nxt      = '0;
        end else begin
          cur_w_nxt = cur_w_r + WORD_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_bytes = {res_page, {PAGE_SHIFT{1'b0}}};

  always_comb begin
    out_data_nxt              = out_data_r;
    if (out_valid_nxt) begin
      out_data_nxt.status       = res_status;
      out_data_nxt.page_address = res_has_page ? ADDR_W'(res_bytes) : '0;
      out_data_nxt.used_pages   = used_count_nxt;
      out_data_nxt.free_pages   = (eff_limit > used_count_nxt) ?
                                  (eff_limit - used_count_nxt) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cur_w_r      <= '0;
      used_count_r <= RESET_RESERVED;
      clr_n_r      <= RESET_RESERVED;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
      limit_r      <= RESET_LIMIT;
      reserved_r   <= RESET_RESERVED;
    end else begin
      state_r      <= state_nxt;
      cur_w_r      <= cur_w_nxt;
      used_count_r <= used_count_nxt;
      clr_n_r      <= clr_n_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_write && cfg_paddr[2] == REG_PAGE_LIMIT) begin
        limit_r <= cfg_pwdata[CNT_W-1:0];
      end
      if (cfg_write && cfg_paddr[2] == REG_RESERVED) begin
        reserved_r <= cfg_pwdata[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    free_w_r   <= free_w_nxt;
    free_bit_r <= free_bit_nxt;
    out_data_r <= out_data_nxt;
  end

  bpa_ram #(
    .DEPTH(BITMAP_WORDS),
    .WIDTH(WORD_BITS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_RESERVED) ?
                      CFG_DATA_W'(reserved_r) : CFG_DATA_W'(limit_r);

  a_reject_now: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.operation == OP_FREE && !free_ok
    |=> out_valid && out_data.status == ST_REJECT && !busy)
    else $error("rejected free did not report at once");

  a_free_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FREE |=> out_valid && state_r == S_IDLE)
    else $error("free transfer did not complete in one write-back");

  a_alloc_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC && alloc_found
    |=> out_valid && out_data.status == ST_DONE && used_count_r != '0)
    else $error("allocation hit not reported");

  a_no_page_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |-> out_data.page_address == '0)
    else $error("page address set on failed command");

endmodule

@@ rtl/bpa_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
module bpa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
